// ----- sv/segment_intersection_param_macros.svh -----
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_PARAM_MACROS_SVH
`define SEGMENT_INTERSECTION_PARAM_MACROS_SVH
`ifndef SYNTHESIS
`define SIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment intersection assertion failed");
`define SIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment intersection assertion failed");
`else
`define SIP_ASSERT_NOW(lbl, ante, cons)
`define SIP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/sip_pkg.sv -----
`timescale 1ns / 1ps
package sip_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int LIMB            = 32;
    localparam int DIV_STEPS       = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARAM_TOL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COS     = 2'd2;

    localparam logic [2:0] KIND_NONE      = 3'd0;
    localparam logic [2:0] KIND_SHARED    = 3'd1;
    localparam logic [2:0] KIND_COLLINEAR = 3'd2;
    localparam logic [2:0] KIND_CROSS     = 3'd3;
    localparam logic [2:0] KIND_DEGEN     = 3'd4;

    typedef struct packed {
        logic signed [31:0] ax0;
        logic signed [31:0] ay0;
        logic signed [31:0] ax1;
        logic signed [31:0] ay1;
        logic signed [31:0] bx0;
        logic signed [31:0] by0;
        logic signed [31:0] bx1;
        logic signed [31:0] by1;
    } t_in;

    typedef struct packed {
        logic              hit;
        logic [2:0]        hit_kind;
        logic signed [31:0] t_param;
    } t_out;

    typedef struct packed {
        logic        hit;
        logic [2:0]  kind;
        logic        use_div;
        logic        neg;
        logic [31:0] t_fix;
    } t_div_side;

endpackage

// ----- sv/sip_mul.sv -----
`timescale 1ns / 1ps
module sip_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [WA-1:0]     i_a,
    input  logic [WB-1:0]     i_b,
    output logic [WA+WB-1:0]  o_p
);

    localparam int L  = sip_pkg::LIMB;
    localparam int NA = (WA + L - 1) / L;
    localparam int NB = (WB + L - 1) / L;
    localparam int PW = (NA + NB) * L;

    logic [NA*L-1:0]  a_ext;
    logic [NB*L-1:0]  b_ext;
    logic [2*L-1:0]   r_pp [NA*NB];
    logic [PW-1:0]    n_sum;
    logic [WA+WB-1:0] r_p;

    assign a_ext = (NA*L)'(i_a);
    assign b_ext = (NB*L)'(i_b);

    // limb partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i*NB+j] <= (2*L)'(a_ext[i*L +: L]) * (2*L)'(b_ext[j*L +: L]);
                end
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_sum = n_sum + (PW'(r_pp[i*NB+j]) << (L*(i+j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_sum[WA+WB-1:0];
        end
    end

    assign o_p = r_p;

endmodule

// ----- sv/sip_div.sv -----
`timescale 1ns / 1ps
module sip_div #(
    parameter int NW = 67,
    parameter int FB = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [NW-1:0]          i_num,
    input  logic [NW-1:0]          i_den,
    input  sip_pkg::t_div_side     i_side,
    output sip_pkg::t_div_side     o_side,
    output logic signed [31:0]     o_t
);

    localparam int S  = sip_pkg::DIV_STEPS;
    localparam int RW = NW + S + 1;
    localparam logic [S:0] Q_NEG_LIM = (S+1)'(1) << (S-1);
    localparam logic [S:0] Q_POS_LIM = Q_NEG_LIM - (S+1)'(1);

    logic [RW-1:0]      r_rem  [S+1];
    logic [S-1:0]       r_q    [S+1];
    logic [NW-1:0]      r_den  [S+1];
    sip_pkg::t_div_side r_side [S+1];
    logic [S:0]         r_ovf;
    logic [S:0]         r_dz;

    logic [RW-1:0] n_rem0;
    logic [S:0]    q_full;

    assign n_rem0 = RW'(i_num) << FB;

    // overflow and zero divisor checks
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n_rem0;
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            r_ovf[0]  <= n_rem0 >= (RW'(i_den) << S);
            r_dz[0]   <= i_den == '0;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar s = 0; s < S; s++) begin : g_step
        localparam int K = S - 1 - s;
        logic [RW-1:0] d;
        logic [RW-1:0] n_rem;
        logic [S-1:0]  n_q;
        always_comb begin
            d     = RW'(r_den[s]) << K;
            n_rem = r_rem[s];
            n_q   = r_q[s];
            if (r_rem[s] >= d) begin
                n_rem  = r_rem[s] - d;
                n_q[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1]  <= n_rem;
                r_q[s+1]    <= n_q;
                r_den[s+1]  <= r_den[s];
                r_side[s+1] <= r_side[s];
                r_ovf[s+1]  <= r_ovf[s];
                r_dz[s+1]   <= r_dz[s];
            end
        end
    end

    assign q_full = r_ovf[S] ? ((S+1)'(1) << S) : {1'b0, r_q[S]};

    // t_fix when no division is used, zero for a zero divisor, else truncate toward zero, then saturate
    always_comb begin
        if (!r_side[S].use_div) begin
            o_t = r_side[S].t_fix;
        end else if (r_dz[S]) begin
            o_t = '0;
        end else if (r_side[S].neg) begin
            if (q_full > Q_NEG_LIM) begin
                o_t = Q_NEG_LIM[S-1:0];
            end else begin
                o_t = -q_full[S-1:0];
            end
        end else begin
            if (q_full > Q_POS_LIM) begin
                o_t = Q_POS_LIM[S-1:0];
            end else begin
                o_t = q_full[S-1:0];
            end
        end
    end

    assign o_side = r_side[S];

endmodule

// ----- sv/segment_intersection_param.sv -----
`timescale 1ns / 1ps
// throughput: one segment pair per cycle; every stage moves together unless the output stalls
// the latency is set by the 32-stage restoring divider that forms t, plus the limb multipliers,
// sums and compares ahead of it
// reset: synchronous active low; clears the valid pipeline and loads config defaults
module segment_intersection_param #(
    parameter int FRAC_BITS   = sip_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  sip_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output sip_pkg::t_out                     o_data,
    input  logic                              i_cfg_we,
    input  logic [sip_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sip_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    `include "segment_intersection_param_macros.svh"

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int IW    = (W > 32) ? W : 32;
    localparam int DW    = W + 1;
    localparam int MW    = 2 * DW + 1;
    localparam int SW    = MW + 1;
    localparam int TOLW  = 16;
    localparam int TOL2W = 32;
    localparam int MCW   = 32;
    localparam int MC2W  = 64;
    localparam int THRW  = 32 + F;
    localparam int XW    = MW + F + TOLW + 1;
    localparam int NPR   = 24;
    localparam int NST   = 11 + sip_pkg::DIV_STEPS + 2;
    localparam logic [MCW-1:0]   MC_RST  = 32'd43;
    localparam logic [MC2W-1:0]  MC2_RST = MC2W'(MC_RST) * MC2W'(MC_RST);
    localparam logic [31:0]      T_ONE   = 32'(1) << F;

    typedef struct packed {
        logic [MW-1:0] la;
        logic [MW-1:0] cm;
        logic [MW-1:0] dtm0;
        logic [MW-1:0] dtm1;
        logic [MW-1:0] nm;
        logic          dtn0;
        logic          dtn1;
        logic          nneg;
        logic [3:0]    se;
        logic          dega;
        logic          degb;
        logic          cz;
    } t_mid;

    typedef struct packed {
        logic on0;
        logic on1;
        logic inr0;
        logic inr1;
        logic inrn;
    } t_flags;

    function automatic logic signed [W-1:0] coord(logic [31:0] v);
        logic [IW-1:0] z;
        z = IW'(v);
        return signed'(z[W-1:0]);
    endfunction

    function automatic logic signed [DW-1:0] dsub(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
        return {a[W-1], a} - {b[W-1], b};
    endfunction

    function automatic logic [DW-1:0] dmag(logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    function automatic logic signed [SW-1:0] sgn(logic [2*DW-1:0] p, logic s);
        logic signed [SW-1:0] v;
        v = signed'(SW'(p));
        return s ? -v : v;
    endfunction

    function automatic logic [MW-1:0] smag(logic signed [SW-1:0] x);
        logic signed [SW-1:0] v;
        v = x[SW-1] ? -x : x;
        return v[MW-1:0];
    endfunction

    // tol < num/den < 1 - tol, lo = tol * den
    function automatic logic inr(logic neg, logic [MW-1:0] mag, logic [MW-1:0] den,
                                 logic [TOLW+MW-1:0] lo);
        logic [XW-1:0] nm;
        logic [XW-1:0] lw;
        logic [XW-1:0] dn;
        nm = XW'(mag) << F;
        lw = XW'(lo);
        dn = XW'(den) << F;
        return !(neg && (mag != '0)) && (lw < nm) && ((nm + lw) < dn);
    endfunction

    // configuration
    logic [31:0]      r_dist_tol_sq;
    logic [TOLW-1:0]  r_param_tol;
    logic [MCW-1:0]   r_min_cos;
    logic [TOL2W-1:0] r_tol2;
    logic [MC2W-1:0]  r_mc2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_tol_sq <= 32'd1;
            r_param_tol   <= TOLW'(1);
            r_min_cos     <= MC_RST;
            r_tol2        <= TOL2W'(1);
            r_mc2         <= MC2_RST;
        end else begin
            r_tol2 <= TOL2W'(r_param_tol) * TOL2W'(r_param_tol);
            r_mc2  <= MC2W'(r_min_cos) * MC2W'(r_min_cos);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sip_pkg::CFG_DIST_TOL_SQ: r_dist_tol_sq <= i_cfg_data;
                    sip_pkg::CFG_PARAM_TOL:   r_param_tol   <= i_cfg_data[TOLW-1:0];
                    sip_pkg::CFG_MIN_COS:     r_min_cos     <= i_cfg_data[MCW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // pipeline control
    logic           en;
    logic [NST-1:0] r_vld;

    assign en      = !(r_vld[NST-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 0: input capture
    logic signed [W-1:0] r0_c [8];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_c[0] <= coord(i_data.ax0);
            r0_c[1] <= coord(i_data.ay0);
            r0_c[2] <= coord(i_data.ax1);
            r0_c[3] <= coord(i_data.ay1);
            r0_c[4] <= coord(i_data.bx0);
            r0_c[5] <= coord(i_data.by0);
            r0_c[6] <= coord(i_data.bx1);
            r0_c[7] <= coord(i_data.by1);
        end
    end

    // stage 1: differences and operand magnitudes
    logic signed [DW-1:0] dx [8];
    logic signed [DW-1:0] dy [8];
    logic signed [DW-1:0] opa [NPR];
    logic signed [DW-1:0] opb [NPR];
    logic [DW-1:0]        r1_ma [NPR];
    logic [DW-1:0]        r1_mb [NPR];
    logic [NPR-1:0]       r1_sg;

    always_comb begin
        // endpoint pairs a0b0 a0b1 a1b0 a1b1, then a, b, b0-a0, b1-a0
        dx[0] = dsub(r0_c[0], r0_c[4]);  dy[0] = dsub(r0_c[1], r0_c[5]);
        dx[1] = dsub(r0_c[0], r0_c[6]);  dy[1] = dsub(r0_c[1], r0_c[7]);
        dx[2] = dsub(r0_c[2], r0_c[4]);  dy[2] = dsub(r0_c[3], r0_c[5]);
        dx[3] = dsub(r0_c[2], r0_c[6]);  dy[3] = dsub(r0_c[3], r0_c[7]);
        dx[4] = dsub(r0_c[2], r0_c[0]);  dy[4] = dsub(r0_c[3], r0_c[1]);
        dx[5] = dsub(r0_c[6], r0_c[4]);  dy[5] = dsub(r0_c[7], r0_c[5]);
        dx[6] = dsub(r0_c[4], r0_c[0]);  dy[6] = dsub(r0_c[5], r0_c[1]);
        dx[7] = dsub(r0_c[6], r0_c[0]);  dy[7] = dsub(r0_c[7], r0_c[1]);
        for (int i = 0; i < 6; i++) begin
            opa[2*i]   = dx[i];  opb[2*i]   = dx[i];
            opa[2*i+1] = dy[i];  opb[2*i+1] = dy[i];
        end
        opa[12] = dx[4];  opb[12] = dy[5];
        opa[13] = dy[4];  opb[13] = dx[5];
        opa[14] = dx[4];  opb[14] = dy[6];
        opa[15] = dy[4];  opb[15] = dx[6];
        opa[16] = dx[4];  opb[16] = dy[7];
        opa[17] = dy[4];  opb[17] = dx[7];
        opa[18] = dx[6];  opb[18] = dx[4];
        opa[19] = dy[6];  opb[19] = dy[4];
        opa[20] = dx[7];  opb[20] = dx[4];
        opa[21] = dy[7];  opb[21] = dy[4];
        opa[22] = dx[6];  opb[22] = dy[5];
        opa[23] = dy[6];  opb[23] = dx[5];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NPR; k++) begin
                r1_ma[k] <= dmag(opa[k]);
                r1_mb[k] <= dmag(opb[k]);
                r1_sg[k] <= opa[k][DW-1] ^ opb[k][DW-1];
            end
        end
    end

    // stages 2-3: first product bank
    logic [2*DW-1:0] m1_p [NPR];
    logic [NPR-1:0]  r2_sg;
    logic [NPR-1:0]  r3_sg;

    for (genvar k = 0; k < NPR; k++) begin : g_m1
        sip_mul #(.WA(DW), .WB(DW)) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r1_ma[k]),
            .i_b   (r1_mb[k]),
            .o_p   (m1_p[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sg <= r1_sg;
            r3_sg <= r2_sg;
        end
    end

    // stage 4: norms, cross and dot products
    logic [MW-1:0]        r4_nrm [4];
    logic [MW-1:0]        r4_la;
    logic [MW-1:0]        r4_lb;
    logic signed [SW-1:0] r4_c;
    logic signed [SW-1:0] r4_cr0;
    logic signed [SW-1:0] r4_cr1;
    logic signed [SW-1:0] r4_dt0;
    logic signed [SW-1:0] r4_dt1;
    logic signed [SW-1:0] r4_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r4_nrm[i] <= MW'(m1_p[2*i]) + MW'(m1_p[2*i+1]);
            end
            r4_la  <= MW'(m1_p[8]) + MW'(m1_p[9]);
            r4_lb  <= MW'(m1_p[10]) + MW'(m1_p[11]);
            r4_c   <= sgn(m1_p[12], r3_sg[12]) - sgn(m1_p[13], r3_sg[13]);
            r4_cr0 <= sgn(m1_p[14], r3_sg[14]) - sgn(m1_p[15], r3_sg[15]);
            r4_cr1 <= sgn(m1_p[16], r3_sg[16]) - sgn(m1_p[17], r3_sg[17]);
            r4_dt0 <= sgn(m1_p[18], r3_sg[18]) + sgn(m1_p[19], r3_sg[19]);
            r4_dt1 <= sgn(m1_p[20], r3_sg[20]) + sgn(m1_p[21], r3_sg[21]);
            r4_n   <= sgn(m1_p[22], r3_sg[22]) - sgn(m1_p[23], r3_sg[23]);
        end
    end

    // stage 5: magnitudes and early flags
    logic [THRW-1:0] thr;
    t_mid            r5_m;
    logic [MW-1:0]   r5_lb;
    logic [MW-1:0]   r5_crm0;
    logic [MW-1:0]   r5_crm1;

    assign thr = {r_dist_tol_sq, F'(0)};

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r5_m.se[i] <= (MW+THRW)'(r4_nrm[i]) < (MW+THRW)'(thr);
            end
            r5_m.la   <= r4_la;
            r5_m.cm   <= smag(r4_c);
            r5_m.dtm0 <= smag(r4_dt0);
            r5_m.dtm1 <= smag(r4_dt1);
            r5_m.nm   <= smag(r4_n);
            r5_m.dtn0 <= r4_dt0[SW-1];
            r5_m.dtn1 <= r4_dt1[SW-1];
            r5_m.nneg <= r4_n[SW-1] ^ r4_c[SW-1];
            r5_m.dega <= (MW+TOL2W)'(r4_la) < (MW+TOL2W)'(r_tol2);
            r5_m.degb <= (MW+TOL2W)'(r4_lb) < (MW+TOL2W)'(r_tol2);
            r5_m.cz   <= r4_c == '0;
            r5_lb     <= r4_lb;
            r5_crm0   <= smag(r4_cr0);
            r5_crm1   <= smag(r4_cr1);
        end
    end

    // stages 6-7: second product bank
    logic [2*MW-1:0]      m2_c2;
    logic [2*MW-1:0]      m2_cr0;
    logic [2*MW-1:0]      m2_cr1;
    logic [TOL2W+MW-1:0]  m2_t2la;
    logic [2*MW-1:0]      m2_lalb;
    logic [TOLW+MW-1:0]   m2_tla;
    logic [TOLW+MW-1:0]   m2_tc;
    t_mid                 r6_m;
    t_mid                 r7_m;

    sip_mul #(.WA(MW), .WB(MW)) u_c2 (
        .i_clk (i_clk), .i_en (en), .i_a (r5_m.cm), .i_b (r5_m.cm), .o_p (m2_c2)
    );
    sip_mul #(.WA(MW), .WB(MW)) u_cr0 (
        .i_clk (i_clk), .i_en (en), .i_a (r5_crm0), .i_b (r5_crm0), .o_p (m2_cr0)
    );
    sip_mul #(.WA(MW), .WB(MW)) u_cr1 (
        .i_clk (i_clk), .i_en (en), .i_a (r5_crm1), .i_b (r5_crm1), .o_p (m2_cr1)
    );
    sip_mul #(.WA(TOL2W), .WB(MW)) u_t2la (
        .i_clk (i_clk), .i_en (en), .i_a (r_tol2), .i_b (r5_m.la), .o_p (m2_t2la)
    );
    sip_mul #(.WA(MW), .WB(MW)) u_lalb (
        .i_clk (i_clk), .i_en (en), .i_a (r5_m.la), .i_b (r5_lb), .o_p (m2_lalb)
    );
    sip_mul #(.WA(TOLW), .WB(MW)) u_tla (
        .i_clk (i_clk), .i_en (en), .i_a (r_param_tol), .i_b (r5_m.la), .o_p (m2_tla)
    );
    sip_mul #(.WA(TOLW), .WB(MW)) u_tc (
        .i_clk (i_clk), .i_en (en), .i_a (r_param_tol), .i_b (r5_m.cm), .o_p (m2_tc)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_m <= r5_m;
            r7_m <= r6_m;
        end
    end

    // stage 8: on-line and range tests; stages 8-9: parallel threshold product
    t_mid                  r8_m;
    t_flags                r8_f;
    logic [2*MW-1:0]       r8_c2;
    t_mid                  r9_m;
    t_flags                r9_f;
    logic [2*MW-1:0]       r9_c2;
    logic [2*MW+MC2W-1:0]  m3_rhs;

    sip_mul #(.WA(2*MW), .WB(MC2W)) u_rhs (
        .i_clk (i_clk), .i_en (en), .i_a (m2_lalb), .i_b (r_mc2), .o_p (m3_rhs)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_m      <= r7_m;
            r8_c2     <= m2_c2;
            r8_f.on0  <= (2*MW+TOL2W)'(m2_cr0) < (2*MW+TOL2W)'(m2_t2la);
            r8_f.on1  <= (2*MW+TOL2W)'(m2_cr1) < (2*MW+TOL2W)'(m2_t2la);
            r8_f.inr0 <= inr(r7_m.dtn0, r7_m.dtm0, r7_m.la, m2_tla);
            r8_f.inr1 <= inr(r7_m.dtn1, r7_m.dtm1, r7_m.la, m2_tla);
            r8_f.inrn <= inr(r7_m.nneg, r7_m.nm, r7_m.cm, m2_tc);
            r9_m      <= r8_m;
            r9_f      <= r8_f;
            r9_c2     <= r8_c2;
        end
    end

    // stage 10: case selection and divider operands
    logic               par;
    sip_pkg::t_div_side n_side;
    logic [MW-1:0]      n_num;
    logic [MW-1:0]      n_den;
    sip_pkg::t_div_side r10_side;
    logic [MW-1:0]      r10_num;
    logic [MW-1:0]      r10_den;

    assign par = r9_m.cz || ({r9_c2, MC2W'(0)} < m3_rhs);

    always_comb begin
        n_side.hit     = 1'b0;
        n_side.kind    = sip_pkg::KIND_NONE;
        n_side.use_div = 1'b0;
        n_side.neg     = 1'b0;
        n_side.t_fix   = '0;
        n_num          = r9_m.nm;
        n_den          = r9_m.cm;
        if (r9_m.se != 4'b0000) begin
            n_side.hit   = 1'b1;
            n_side.kind  = sip_pkg::KIND_SHARED;
            n_side.t_fix = (r9_m.se[0] || r9_m.se[1]) ? 32'd0 : T_ONE;
        end else if (r9_m.dega || r9_m.degb) begin
            n_side.kind = sip_pkg::KIND_DEGEN;
        end else if (par) begin
            n_den = r9_m.la;
            if (r9_f.on0 && r9_f.inr0) begin
                n_side.hit     = 1'b1;
                n_side.kind    = sip_pkg::KIND_COLLINEAR;
                n_side.use_div = 1'b1;
                n_side.neg     = r9_m.dtn0;
                n_num          = r9_m.dtm0;
            end else if (r9_f.on1 && r9_f.inr1) begin
                n_side.hit     = 1'b1;
                n_side.kind    = sip_pkg::KIND_COLLINEAR;
                n_side.use_div = 1'b1;
                n_side.neg     = r9_m.dtn1;
                n_num          = r9_m.dtm1;
            end
        end else begin
            n_side.use_div = 1'b1;
            n_side.neg     = r9_m.nneg;
            if (r9_f.inrn) begin
                n_side.hit  = 1'b1;
                n_side.kind = sip_pkg::KIND_CROSS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_side <= n_side;
            r10_num  <= n_num;
            r10_den  <= n_den;
        end
    end

    // stages 11-43: divider, then output register
    sip_pkg::t_div_side div_side;
    logic signed [31:0] div_t;
    sip_pkg::t_out      r_out;

    sip_div #(.NW(MW), .FB(F)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r10_num),
        .i_den  (r10_den),
        .i_side (r10_side),
        .o_side (div_side),
        .o_t    (div_t)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit      <= div_side.hit;
            r_out.hit_kind <= div_side.kind;
            r_out.t_param  <= div_t;
        end
    end

    assign o_data = r_out;

    `SIP_ASSERT_NEXT(a_frozen_on_stall, o_stall, $stable(r_vld))
    `SIP_ASSERT_NOW(a_hit_kind, o_valid && o_data.hit, o_data.hit_kind == sip_pkg::KIND_SHARED || o_data.hit_kind == sip_pkg::KIND_COLLINEAR || o_data.hit_kind == sip_pkg::KIND_CROSS)
    `SIP_ASSERT_NOW(a_degen_out, o_valid && o_data.hit_kind == sip_pkg::KIND_DEGEN, !o_data.hit && o_data.t_param == 32'sd0)
    `SIP_ASSERT_NOW(a_shared_t, o_valid && o_data.hit_kind == sip_pkg::KIND_SHARED, o_data.t_param == 32'sd0 || o_data.t_param == signed'(T_ONE))

endmodule
